FILE: src/gpld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpld_pkg
// Shared types and constants for the gamma-corrected PWM LED dimmer:
// opcodes, status codes, register map base, limits and the gamma table.
// ----------------------------------------------------------------------------
package gpld_pkg;

	typedef logic [1:0]  opcode_t;
	typedef logic [15:0] reg_word_t;
	typedef logic [9:0]  duty_t;

	localparam opcode_t OP_TICK  = 2'd0;
	localparam opcode_t OP_READ  = 2'd1;
	localparam opcode_t OP_WRITE = 2'd2;

	localparam logic STATUS_OK           = 1'b0;
	localparam logic STATUS_ILLEGAL_ADDR = 1'b1;

	localparam reg_word_t BASE_ADDR      = 16'd40001;
	localparam reg_word_t RAW_LIMIT      = 16'd1001;
	localparam reg_word_t LEVEL_RAW_MARK = 16'hffff;
	localparam duty_t     PERIOD_RESET   = 10'd1000;
	localparam duty_t     DUTY_MAX       = 10'd1000;

	localparam int GAMMA_TAB_LEN = 101;
	localparam int GAMMA_ENTRIES = 101;
	// a level must index both the configured entries and the table itself
	localparam int LEVEL_LIMIT   = (GAMMA_ENTRIES < GAMMA_TAB_LEN) ? GAMMA_ENTRIES
	                                                               : GAMMA_TAB_LEN;
	localparam int GAMMA_IDX_W   = $clog2(GAMMA_TAB_LEN);

	localparam duty_t GAMMA_TABLE [0:GAMMA_TAB_LEN-1] = '{
		10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd1,   10'd1,
		10'd1,   10'd1,   10'd1,   10'd1,   10'd1,   10'd1,   10'd2,   10'd2,
		10'd2,   10'd2,   10'd2,   10'd3,   10'd3,   10'd3,   10'd4,   10'd4,
		10'd4,   10'd5,   10'd5,   10'd5,   10'd6,   10'd6,   10'd7,   10'd8,
		10'd8,   10'd9,   10'd9,   10'd10,  10'd11,  10'd12,  10'd13,  10'd14,
		10'd15,  10'd16,  10'd17,  10'd18,  10'd20,  10'd21,  10'd23,  10'd25,
		10'd27,  10'd29,  10'd31,  10'd33,  10'd35,  10'd38,  10'd41,  10'd44,
		10'd47,  10'd50,  10'd54,  10'd58,  10'd62,  10'd67,  10'd71,  10'd77,
		10'd82,  10'd88,  10'd94,  10'd101, 10'd109, 10'd116, 10'd125, 10'd134,
		10'd144, 10'd154, 10'd165, 10'd177, 10'd190, 10'd203, 10'd218, 10'd233,
		10'd250, 10'd268, 10'd287, 10'd308, 10'd330, 10'd354, 10'd379, 10'd406,
		10'd436, 10'd467, 10'd500, 10'd536, 10'd574, 10'd616, 10'd660, 10'd707,
		10'd758, 10'd812, 10'd870, 10'd932, 10'd1000
	};

endpackage

FILE: src/gamma_pwm_led_dimmer_registers_top.sv
`timescale 1ns / 1ps
// Pipeline: an accepted beat lands in the input register, and its result
// loads into the result register once that register is free or out_ready is high.
// Throughput: one item per cycle while out_ready is high; the single
// state update per item settles in the same cycle the result register loads.
// Reset: arst_n clears levels, duties and the PWM counter to zero, and loads
// pwm_period with 1000; nothing is in flight after reset.
// ----------------------------------------------------------------------------
// gamma_pwm_led_dimmer_registers_top
// Three-channel gamma-corrected PWM LED dimmer with a small holding-register
// bank: ticks advance the shared counter, reads and writes reach level/duty.
// ----------------------------------------------------------------------------
module gamma_pwm_led_dimmer_registers_top #(
	parameter int CHANNEL_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] reg_address,
	input  logic [15:0] write_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] read_data,
	output logic        status,
	output logic [2:0]  pwm_lines
);

	localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam gpld_pkg::reg_word_t CH_CNT   = 16'(CHANNEL_COUNT);
	localparam gpld_pkg::reg_word_t CH_CNT_2 = 16'(2 * CHANNEL_COUNT);

	// state
	gpld_pkg::duty_t     pwm_period_q;
	gpld_pkg::duty_t     pwm_count_q;
	gpld_pkg::reg_word_t channel_level_q [CHANNEL_COUNT];
	gpld_pkg::duty_t     channel_duty_q  [CHANNEL_COUNT];

	// input stage
	logic                s1_valid_q;
	gpld_pkg::opcode_t   opcode_s1;
	gpld_pkg::reg_word_t reg_address_s1;
	gpld_pkg::reg_word_t write_value_s1;

	// result stage
	logic                out_valid_q;
	gpld_pkg::reg_word_t read_data_s2;
	logic                status_s2;
	logic [2:0]          pwm_lines_s2;

	logic                advance;
	logic                in_beat;
	gpld_pkg::reg_word_t offset;
	gpld_pkg::reg_word_t duty_off;
	logic                addr_ge_base;
	logic                is_level;
	logic                is_duty;
	logic                is_access;
	logic [CH_W-1:0]     ch;
	logic                level_ok;
	logic                raw_ok;
	logic [gpld_pkg::GAMMA_IDX_W-1:0] gamma_idx;
	gpld_pkg::duty_t     gamma_duty;
	gpld_pkg::reg_word_t rd_value;
	logic                st_value;
	logic [2:0]          lines_now;
	logic                do_tick;
	logic                wr_level;
	logic                wr_raw;

	assign advance  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || advance;
	assign in_beat  = in_valid && in_ready;

	// address decode
	always_comb begin
		offset       = reg_address_s1 - gpld_pkg::BASE_ADDR;
		duty_off     = offset - CH_CNT;
		addr_ge_base = reg_address_s1 >= gpld_pkg::BASE_ADDR;
		is_access    = (opcode_s1 == gpld_pkg::OP_READ) || (opcode_s1 == gpld_pkg::OP_WRITE);
		is_level     = is_access && addr_ge_base && (offset < CH_CNT);
		is_duty      = is_access && addr_ge_base && (offset >= CH_CNT) && (offset < CH_CNT_2);
		ch           = is_duty ? duty_off[CH_W-1:0] : offset[CH_W-1:0];
	end

	assign level_ok   = write_value_s1 < 16'(gpld_pkg::LEVEL_LIMIT);
	assign raw_ok     = write_value_s1 < gpld_pkg::RAW_LIMIT;
	assign gamma_idx  = level_ok ? write_value_s1[gpld_pkg::GAMMA_IDX_W-1:0] : '0;
	assign gamma_duty = gpld_pkg::GAMMA_TABLE[gamma_idx];

	assign do_tick  = advance && (opcode_s1 == gpld_pkg::OP_TICK);
	assign wr_level = advance && (opcode_s1 == gpld_pkg::OP_WRITE) && is_level && level_ok;
	assign wr_raw   = advance && (opcode_s1 == gpld_pkg::OP_WRITE) && is_duty && raw_ok;

	// lines are sampled before this item's own update
	always_comb begin
		lines_now = '0;
		for (int k = 0; k < 3; k++) begin
			if (k < CHANNEL_COUNT) begin
				lines_now[k] = pwm_count_q < channel_duty_q[k];
			end
		end
	end

	always_comb begin
		rd_value = '0;
		st_value = gpld_pkg::STATUS_OK;
		if (is_access && !is_level && !is_duty) begin
			st_value = gpld_pkg::STATUS_ILLEGAL_ADDR;
		end
		if (opcode_s1 == gpld_pkg::OP_READ) begin
			if (is_level) begin
				rd_value = channel_level_q[ch];
			end else if (is_duty) begin
				rd_value = 16'(channel_duty_q[ch]);
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			opcode_s1      <= opcode;
			reg_address_s1 <= reg_address;
			write_value_s1 <= write_value;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2 <= rd_value;
			status_s2    <= st_value;
			pwm_lines_s2 <= lines_now;
		end
	end

	// config and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= gpld_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			pwm_period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_count_q <= '0;
		end else if (do_tick) begin
			if (pwm_count_q >= pwm_period_q) begin
				pwm_count_q <= '0;
			end else begin
				pwm_count_q <= pwm_count_q + 10'd1;
			end
		end
	end

	// level and duty bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHANNEL_COUNT; k++) begin
				channel_level_q[k] <= '0;
				channel_duty_q[k]  <= '0;
			end
		end else if (wr_level) begin
			channel_level_q[ch] <= write_value_s1;
			channel_duty_q[ch]  <= gamma_duty;
		end else if (wr_raw) begin
			channel_level_q[ch] <= gpld_pkg::LEVEL_RAW_MARK;
			channel_duty_q[ch]  <= write_value_s1[9:0];
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_s2;
	assign status    = status_s2;
	assign pwm_lines = pwm_lines_s2;

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (s1_valid_q && out_valid_q && !out_ready))
		else $error("input stalled without a full pipeline");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!do_tick |=> $stable(pwm_count_q))
		else $error("pwm counter moved without a tick");

	a_count_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(do_tick && (pwm_count_q >= pwm_period_q)) |=> (pwm_count_q == '0))
		else $error("pwm counter failed to wrap");

	a_illegal_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_s2 == gpld_pkg::STATUS_ILLEGAL_ADDR)) |-> (read_data_s2 == '0))
		else $error("illegal address beat carries data");

	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_level || wr_raw) |=> (channel_duty_q[$past(ch)] <= gpld_pkg::DUTY_MAX))
		else $error("duty written above full scale");

endmodule
